// File: hw/rtl/wah_pkg.sv
// Shared constants, types and codes for the window alarm block.
`timescale 1ns / 1ps

package wah_pkg;

	// Channel count and converter resolution.
	localparam int CHANNELS    = 8;
	localparam int SAMPLE_BITS = 12;

	// Fixed field widths of the item and configuration ports.
	localparam int CH_W     = 3;
	localparam int SAMPLE_W = 12;
	localparam int LIMIT_W  = 13;
	localparam int COUNT_W  = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W    = 13;

	// Address width of the per-channel entry memory.
	localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Compare width holds a full-scale value plus a margin without overflow.
	localparam int CMP_W = SAMPLE_BITS + 2;

	localparam logic [CMP_W-1:0]    FULL_SCALE  = CMP_W'(1) << SAMPLE_BITS;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((CMP_W'(1) << SAMPLE_BITS) - 1);
	localparam logic [COUNT_W-1:0]  COUNT_MAX   = '1;

	localparam logic [LIMIT_W-1:0] LOWER_RESET  = '0;
	localparam logic [LIMIT_W-1:0] UPPER_RESET  = LIMIT_W'(FULL_SCALE);
	localparam logic [LIMIT_W-1:0] MARGIN_RESET = LIMIT_W'(100);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 1'b1;

	// Item operation codes.
	localparam logic OP_CHECK = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef enum logic [1:0] {
		MARK_NONE = 2'd0,
		MARK_HIGH = 2'd1,
		MARK_LOW  = 2'd2
	} mark_t;

	// One channel's stored state.
	typedef struct packed {
		logic [LIMIT_W-1:0] lower;
		logic [LIMIT_W-1:0] upper;
		mark_t              mark;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{lower: LOWER_RESET, upper: UPPER_RESET, mark: MARK_NONE};

endpackage

// File: hw/rtl/window_alarm_with_hysteresis.sv
// Top level of the multi-channel window alarm with hysteresis.
//
// Items arrive on a valid/ready input channel. A write item loads one
// channel's lower and upper limit; a check item compares one channel's
// sample with its window and updates that channel's alarm mark. Every item
// gives exactly one result on the valid/ready output channel, in order.
// Channel enables and the release margin come through a plain write port;
// change them only while the block is idle; the block does not enforce it.
//
// The channel entry is read from the memory at the accepting edge, and
// the result is registered in the output register when the read stage
// advances. One item is taken every cycle while the receiver does not
// stall; the read, compare and write-back of the entry memory overlap,
// and a write-back is forwarded to an item on the same channel that read
// the memory at that very edge.
// After reset all limits read as zero and full scale, all marks as none,
// through one valid bit per channel; the scan count and flag are clear.
// When the receiver stalls, the output register holds its result, the item
// in the read stage waits, and the input drops ready if that stage is full.
`timescale 1ns / 1ps

module window_alarm_with_hysteresis import wah_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic [CH_W-1:0]      channel,
	input  logic [SAMPLE_W-1:0]  sample,
	input  logic [LIMIT_W-1:0]   low_limit,
	input  logic [LIMIT_W-1:0]   high_limit,
	input  logic                 scan_start,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_of_range,
	output logic                 new_alarm,
	output logic [1:0]           alarm_state,
	output logic [COUNT_W-1:0]   alert_count,
	output logic                 need_alert,

	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// Configuration registers.
	logic [CHANNELS-1:0] channel_enable_q;
	logic [LIMIT_W-1:0]  release_margin_q;

	// Read stage.
	logic                valid_s1;
	logic                op_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic                in_range_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [LIMIT_W-1:0]  low_limit_s1;
	logic [LIMIT_W-1:0]  high_limit_s1;
	logic                scan_start_s1;

	// Entry memory, its valid bits and the last write-back.
	logic [CHANNELS-1:0] ent_valid_q;
	logic                fwd_valid_q;
	logic [ADDR_W-1:0]   fwd_addr_q;
	entry_t              fwd_data_q;
	entry_t              rdata;

	// Scan accumulators.
	logic [COUNT_W-1:0]  scan_count_q;
	logic                scan_need_q;

	logic                accept;
	logic                advance;
	logic                wr_en;
	logic [ADDR_W-1:0]   in_addr;
	logic                in_range;

	entry_t              cur;
	entry_t              nxt;
	logic                checked;
	logic                oor;
	logic                fresh;
	logic                below;
	logic                above;
	logic                hi_release;
	logic                lo_release;
	logic [CMP_W-1:0]    s_cmp;
	logic [CMP_W-1:0]    lo_cmp;
	logic [CMP_W-1:0]    hi_cmp;
	logic [CMP_W-1:0]    m_cmp;
	logic [COUNT_W-1:0]  cnt_base;
	logic [COUNT_W-1:0]  cnt_next;
	logic                need_base;
	logic                need_next;
	mark_t               state_out;

	assign advance  = !out_valid || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;
	assign in_addr  = ADDR_W'(channel);
	assign in_range = 32'(channel) < CHANNELS;
	assign wr_en    = valid_s1 && advance && in_range_s1;

	wah_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(CHANNELS)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr_s1),
		.wdata(nxt),
		.re   (accept),
		.raddr(in_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_enable_q <= '1;
			release_margin_q <= MARGIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLE: channel_enable_q <= CHANNELS'(cfg_data);
				CFG_MARGIN: release_margin_q <= LIMIT_W'(cfg_data);
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1         <= operation;
			addr_s1       <= in_addr;
			in_range_s1   <= in_range;
			sample_s1     <= sample;
			low_limit_s1  <= low_limit;
			high_limit_s1 <= high_limit;
			scan_start_s1 <= scan_start;
		end
	end

	// The most recent write-back is always current for its channel, so it
	// also covers a read that was issued at the same edge as that write.
	always_comb begin
		if (fwd_valid_q && fwd_addr_q == addr_s1) begin
			cur = fwd_data_q;
		end else if (ent_valid_q[addr_s1]) begin
			cur = rdata;
		end else begin
			cur = ENTRY_RESET;
		end
	end

	always_comb begin
		s_cmp  = CMP_W'(sample_s1 & SAMPLE_MASK);
		lo_cmp = CMP_W'(cur.lower);
		hi_cmp = CMP_W'(cur.upper);
		m_cmp  = CMP_W'(release_margin_q);
		below  = s_cmp < lo_cmp;
		above  = s_cmp > hi_cmp;

		// Release needs the sample back inside by the margin, unless the
		// margin would push the release point past either end of the scale.
		hi_release = (hi_cmp > m_cmp) ? (s_cmp + m_cmp < hi_cmp) : (s_cmp < hi_cmp);
		lo_release = (lo_cmp + m_cmp < FULL_SCALE) ? (s_cmp > lo_cmp + m_cmp)
		                                            : (s_cmp > lo_cmp);

		checked = in_range_s1 && op_s1 == OP_CHECK && channel_enable_q[addr_s1];
		cnt_base  = scan_start_s1 ? '0 : scan_count_q;
		need_base = scan_start_s1 ? 1'b0 : scan_need_q;

		nxt   = cur;
		oor   = 1'b0;
		fresh = 1'b0;
		if (in_range_s1 && op_s1 == OP_WRITE) begin
			nxt.lower = low_limit_s1;
			nxt.upper = high_limit_s1;
		end
		if (checked) begin
			oor = below || above;
			case (cur.mark)
				MARK_HIGH: begin
					if (hi_release) nxt.mark = MARK_NONE;
				end
				MARK_LOW: begin
					if (lo_release) nxt.mark = MARK_NONE;
				end
				default: begin
					// A window with lower above upper can violate both; high wins.
					if (above) begin
						nxt.mark = MARK_HIGH;
						fresh    = 1'b1;
					end else if (below) begin
						nxt.mark = MARK_LOW;
						fresh    = 1'b1;
					end
				end
			endcase
		end

		cnt_next  = (oor && cnt_base != COUNT_MAX) ? cnt_base + 1'b1 : cnt_base;
		need_next = need_base || fresh;
		state_out = in_range_s1 ? nxt.mark : MARK_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q  <= '0;
			fwd_valid_q  <= 1'b0;
			scan_count_q <= '0;
			scan_need_q  <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (wr_en) begin
				ent_valid_q[addr_s1] <= 1'b1;
				fwd_valid_q          <= 1'b1;
			end
			if (valid_s1 && advance) begin
				scan_count_q <= cnt_next;
				scan_need_q  <= need_next;
			end
			if (advance) begin
				out_valid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= nxt;
		end
		if (valid_s1 && advance) begin
			out_of_range <= oor;
			new_alarm    <= fresh;
			alarm_state  <= state_out;
			alert_count  <= cnt_next;
			need_alert   <= need_next;
		end
	end

	// A fresh alarm only comes from an out-of-range sample and marks the scan.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && new_alarm |-> out_of_range && need_alert && alarm_state != MARK_NONE)
		else $error("new alarm without matching range, flag or state");

	// Within a scan the alert count never goes down.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && !scan_start_s1 |=> scan_count_q >= $past(scan_count_q))
		else $error("scan alert count decreased within a scan");

	// A write-back leaves the entry valid and the forward register on it.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> ent_valid_q[$past(addr_s1)] && fwd_valid_q && fwd_addr_q == $past(addr_s1))
		else $error("write-back did not update valid bit or forward register");

	// A stalled read stage must not take a new item.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> !in_ready)
		else $error("input accepted while the read stage is stalled");

endmodule

// File: hw/rtl/wah_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module wah_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
